FILE: rtl/pcrs_pkg.sv
// ----------------------------------------------------------------------------
// Per-cell running statistics package
// Shared constants, the stored cell record and the item kind codes.
// ----------------------------------------------------------------------------
package pcrs_pkg;

    localparam int CELLS_DEFAULT = 65536;
    localparam int COUNT_BITS    = 16;
    localparam int SAMPLE_BITS   = 16;
    localparam int SUM_BITS      = 32;
    localparam int SQ_BITS       = 47;

    typedef enum logic [1:0] {
        KIND_ACCUM = 2'd0,
        KIND_READ  = 2'd1,
        KIND_CLEAR = 2'd2,
        KIND_NONE  = 2'd3
    } kind_t;

    typedef struct packed {
        logic [COUNT_BITS-1:0]         count;
        logic signed [SUM_BITS-1:0]    sum;
        logic [SQ_BITS-1:0]            sq;
        logic signed [SAMPLE_BITS-1:0] min;
        logic signed [SAMPLE_BITS-1:0] max;
    } cell_rec_t;

endpackage

FILE: rtl/pcrs_ram.sv
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module pcrs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

FILE: rtl/per_cell_running_statistics.sv
// ----------------------------------------------------------------------------
// Per-cell running statistics
// Keeps count, sum, sum of squares, minimum and maximum for each grid cell in
// one RAM and answers read transactions with derived mean, variance and root.
// Accumulate and clear transactions read the RAM in FETCH, then write back in UPDATE.
// A read transaction runs two 47-step passes of the shared divider and a 16-step
// square root before its result is presented. A read of an empty cell goes
// straight from UPDATE to EMIT. Output stalls hold a transaction in EMIT.
// One transaction is in work at once.
// After reset a clearing pass writes every cell while s_tready stays low.
// ----------------------------------------------------------------------------
module per_cell_running_statistics #(
    parameter int CELLS = pcrs_pkg::CELLS_DEFAULT
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [31:0]  s_tdata,   // cell_req[15:0], sample_value[31:16]
    input  logic [2:0]   s_tuser,   // kind[1:0], present[2]
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [223:0] m_tdata,   // out_cell, count, minimum, maximum, spread,
                                    // total, total_squares, mean, variance,
                                    // std_dev, zero fill
    output logic         m_tuser    // valid_res
);

    localparam int ADDR_W = (CELLS > 1) ? $clog2(CELLS) : 1;
    localparam int REC_W  = $bits(pcrs_pkg::cell_rec_t);

    typedef enum logic [9:0] {
        ST_CLEAR  = 10'b0000000001,
        ST_IDLE   = 10'b0000000010,
        ST_FETCH  = 10'b0000000100,
        ST_UPDATE = 10'b0000001000,
        ST_DIVSQ  = 10'b0000010000,
        ST_DIVSUM = 10'b0000100000,
        ST_SQUARE = 10'b0001000000,
        ST_VAR    = 10'b0010000000,
        ST_ROOT   = 10'b0100000000,
        ST_EMIT   = 10'b1000000000
    } state_t;

    state_t state_reg, state_next;
    logic [ADDR_W-1:0] clr_addr_reg;

    pcrs_pkg::kind_t   kind_reg;
    logic [15:0]       cell_reg;
    logic signed [15:0] x_reg;
    logic              present_reg;
    logic [31:0]       xsq_reg;

    pcrs_pkg::cell_rec_t rec_reg, rd_rec, wr_rec;
    logic              valid_reg;
    logic [15:0]       rem_reg;
    logic [46:0]       quo_reg;
    logic [5:0]        div_cnt_reg;
    logic [46:0]       msq_reg;
    logic [16:0]       q_reg;
    logic [33:0]       m2_reg;
    logic [30:0]       var_reg;
    logic [31:0]       v_reg, r_reg, bit_reg;
    logic [3:0]        root_cnt_reg;

    logic              out_valid_reg;
    logic [223:0]      out_data_reg;
    logic              out_user_reg;

    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr, rd_addr;
    logic [REC_W-1:0]  rd_data;
    logic              in_range;
    logic              s_fire, out_free;

    logic [16:0] rem_sh, rem_diff;
    logic        div_ge;
    logic [46:0] quo_step;
    logic [31:0] sum_abs;
    logic [31:0] root_try;
    logic [46:0] m2_ext;
    logic [15:0] mean_out;
    logic [15:0] spread_out;

    pcrs_ram #(
        .WIDTH (REC_W),
        .DEPTH (CELLS)
    ) u_ram (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_rec),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign rd_rec   = pcrs_pkg::cell_rec_t'(rd_data);
    assign in_range = 32'(cell_reg) < 32'(CELLS);
    assign s_tready = (state_reg == ST_IDLE);
    assign s_fire   = s_tvalid && s_tready;
    assign out_free = !out_valid_reg || m_tready;
    assign rd_addr  = ADDR_W'(cell_reg);

    assign rem_sh   = {1'b0, rem_reg[15:0]} << 1 | 17'(quo_reg[46]);
    assign rem_diff = rem_sh - {1'b0, rec_reg.count};
    assign div_ge   = rem_sh >= {1'b0, rec_reg.count};
    assign quo_step = {quo_reg[45:0], div_ge};
    assign sum_abs  = rec_reg.sum[31] ? (~rec_reg.sum + 32'd1) : rec_reg.sum;
    assign root_try = r_reg + bit_reg;
    assign m2_ext   = 47'(m2_reg);
    assign mean_out = rec_reg.sum[31] ? (~q_reg[15:0] + 16'd1) : q_reg[15:0];
    assign spread_out = rec_reg.max - rec_reg.min;

    always_comb begin
        wr_en   = 1'b0;
        wr_addr = ADDR_W'(cell_reg);
        wr_rec  = rd_rec;
        if (state_reg == ST_CLEAR) begin
            wr_en   = 1'b1;
            wr_addr = clr_addr_reg;
            wr_rec  = '0;
        end else if (state_reg == ST_UPDATE && in_range) begin
            if (kind_reg == pcrs_pkg::KIND_CLEAR) begin
                wr_en  = 1'b1;
                wr_rec = '0;
            end else if (kind_reg == pcrs_pkg::KIND_ACCUM && present_reg) begin
                if (rd_rec.count == '0) begin
                    wr_en        = 1'b1;
                    wr_rec.count = 16'd1;
                    wr_rec.sum   = 32'(x_reg);
                    wr_rec.sq    = 47'(xsq_reg);
                    wr_rec.min   = x_reg;
                    wr_rec.max   = x_reg;
                end else if (rd_rec.count != '1) begin
                    wr_en        = 1'b1;
                    wr_rec.count = rd_rec.count + 16'd1;
                    wr_rec.sum   = rd_rec.sum + 32'(x_reg);
                    wr_rec.sq    = rd_rec.sq + 47'(xsq_reg);
                    if (x_reg < rd_rec.min) begin
                        wr_rec.min = x_reg;
                    end else if (x_reg > rd_rec.max) begin
                        wr_rec.max = x_reg;
                    end
                end
            end
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR: begin
                if (clr_addr_reg == ADDR_W'(CELLS - 1)) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_fire) begin
                    state_next = ST_FETCH;
                end
            end
            ST_FETCH: state_next = ST_UPDATE;
            ST_UPDATE: begin
                if (kind_reg != pcrs_pkg::KIND_READ) begin
                    state_next = ST_IDLE;
                end else if (in_range && rd_rec.count != '0) begin
                    state_next = ST_DIVSQ;
                end else begin
                    state_next = ST_EMIT;
                end
            end
            ST_DIVSQ: begin
                if (div_cnt_reg == 6'd46) begin
                    state_next = ST_DIVSUM;
                end
            end
            ST_DIVSUM: begin
                if (div_cnt_reg == 6'd46) begin
                    state_next = ST_SQUARE;
                end
            end
            ST_SQUARE: state_next = ST_VAR;
            ST_VAR:    state_next = ST_ROOT;
            ST_ROOT: begin
                if (root_cnt_reg == 4'd15) begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_CLEAR;
            clr_addr_reg  <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (state_reg == ST_CLEAR) begin
                clr_addr_reg <= clr_addr_reg + ADDR_W'(1);
            end
            if (state_reg == ST_EMIT && out_free) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            kind_reg    <= pcrs_pkg::kind_t'(s_tuser[1:0]);
            present_reg <= s_tuser[2];
            cell_reg    <= s_tdata[15:0];
            x_reg       <= s_tdata[31:16];
        end
        if (state_reg == ST_FETCH) begin
            xsq_reg <= 32'(x_reg * x_reg);
        end
        if (state_reg == ST_UPDATE) begin
            rec_reg     <= rd_rec;
            valid_reg   <= in_range && rd_rec.count != '0;
            quo_reg     <= rd_rec.sq;
            rem_reg     <= '0;
            div_cnt_reg <= '0;
        end
        if (state_reg == ST_DIVSQ || state_reg == ST_DIVSUM) begin
            rem_reg     <= div_ge ? rem_diff[15:0] : rem_sh[15:0];
            quo_reg     <= quo_step;
            div_cnt_reg <= div_cnt_reg + 6'd1;
            if (div_cnt_reg == 6'd46) begin
                rem_reg     <= '0;
                div_cnt_reg <= '0;
                if (state_reg == ST_DIVSQ) begin
                    msq_reg <= quo_step;
                    quo_reg <= 47'(sum_abs);
                end else begin
                    q_reg <= quo_step[16:0];
                end
            end
        end
        if (state_reg == ST_SQUARE) begin
            m2_reg <= q_reg * q_reg;
        end
        if (state_reg == ST_VAR) begin
            var_reg      <= (msq_reg > m2_ext) ? 31'(msq_reg - m2_ext) : '0;
            v_reg        <= (msq_reg > m2_ext) ? 32'(msq_reg - m2_ext) : '0;
            r_reg        <= '0;
            bit_reg      <= 32'h4000_0000;
            root_cnt_reg <= '0;
        end
        if (state_reg == ST_ROOT) begin
            if (v_reg >= root_try) begin
                v_reg <= v_reg - root_try;
                r_reg <= (r_reg >> 1) + bit_reg;
            end else begin
                r_reg <= r_reg >> 1;
            end
            bit_reg      <= bit_reg >> 2;
            root_cnt_reg <= root_cnt_reg + 4'd1;
        end
        if (state_reg == ST_EMIT && out_free) begin
            out_user_reg <= valid_reg;
            if (valid_reg) begin
                out_data_reg <= {3'd0, r_reg[15:0], var_reg, mean_out,
                                 rec_reg.sq[45:0], rec_reg.sum, spread_out,
                                 rec_reg.max, rec_reg.min, rec_reg.count,
                                 cell_reg};
            end else begin
                out_data_reg <= {208'd0, cell_reg};
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_user_reg;

endmodule

FILE: dv/testbench.sv
// ----------------------------------------------------------------------------
// Per-cell running statistics testbench
// Streams accumulate, read, clear and no-op transactions with random gaps and
// stalls into the block. A scoreboard keeps its own copy of every touched cell,
// predicts each readout, and compares it field by field with the block.
// ----------------------------------------------------------------------------
typedef struct {
    logic [15:0] cell_idx;
    logic        valid_res;
    logic [15:0] count;
    logic [15:0] minimum;
    logic [15:0] maximum;
    logic [15:0] spread;
    logic [31:0] total;
    logic [45:0] total_squares;
    logic [15:0] mean;
    logic [30:0] variance;
    logic [15:0] std_dev;
} readout_t;

class cell_stats_scoreboard;
    bit [15:0]           cnt[int];
    bit signed [31:0]    sum[int];
    bit [46:0]           sq[int];
    bit signed [15:0]    lo[int];
    bit signed [15:0]    hi[int];
    readout_t            pending_readouts[$];
    int                  failures;

    function longint unsigned int_sqrt(longint unsigned v);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b >>= 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return r;
    endfunction

    function void note_input(pcrs_pkg::kind_t kind, logic [15:0] cell_idx,
                             logic signed [15:0] x, logic present);
        int c;
        longint xv;
        longint s;
        longint mn;
        longint mx;
        longint mu;
        longint unsigned n;
        longint unsigned msq;
        longint unsigned m2;
        longint unsigned v;
        readout_t r;
        c = cell_idx;
        xv = x;
        if (!cnt.exists(c)) cnt[c] = 0;
        case (kind)
            pcrs_pkg::KIND_ACCUM: begin
                if (present) begin
                    if (cnt[c] == 0) begin
                        cnt[c] = 1;
                        sum[c] = xv;
                        sq[c] = xv * xv;
                        lo[c] = x;
                        hi[c] = x;
                    end else if (cnt[c] != 16'hFFFF) begin
                        cnt[c] = cnt[c] + 1;
                        sum[c] = sum[c] + xv;
                        sq[c] = sq[c] + 47'(xv * xv);
                        if (x < lo[c]) lo[c] = x;
                        else if (x > hi[c]) hi[c] = x;
                    end
                end
            end
            pcrs_pkg::KIND_CLEAR: cnt[c] = 0;
            pcrs_pkg::KIND_READ: begin
                r = '{default: '0};
                r.cell_idx = cell_idx;
                if (cnt[c] != 0) begin
                    n = cnt[c];
                    s = sum[c];
                    mn = lo[c];
                    mx = hi[c];
                    mu = s / longint'(n);
                    msq = longint'(sq[c]) / n;
                    m2 = (mu < 0 ? -mu : mu) * (mu < 0 ? -mu : mu);
                    v = (msq > m2) ? msq - m2 : 0;
                    r.valid_res = 1;
                    r.count = n;
                    r.minimum = mn;
                    r.maximum = mx;
                    r.spread = mx - mn;
                    r.total = s;
                    r.total_squares = sq[c][45:0];
                    r.mean = mu;
                    r.variance = v;
                    r.std_dev = int_sqrt(v);
                end
                pending_readouts.push_back(r);
            end
            default: ;
        endcase
    endfunction

    function void field(string name, logic [63:0] exp_v, logic [63:0] act_v);
        if (exp_v !== act_v) begin
            failures++;
            $display("%0t: %s expected %h actual %h", $time, name, exp_v, act_v);
        end
    endfunction

    function void check_result(logic [223:0] d, logic u);
        readout_t e;
        if (pending_readouts.size() == 0) begin
            failures++;
            $display("%0t: readout with none expected, actual %h", $time, d);
            return;
        end
        e = pending_readouts.pop_front();
        field("out_cell", e.cell_idx, d[15:0]);
        field("valid_res", e.valid_res, u);
        field("count", e.count, d[31:16]);
        field("minimum", e.minimum, d[47:32]);
        field("maximum", e.maximum, d[63:48]);
        field("spread", e.spread, d[79:64]);
        field("total", e.total, d[111:80]);
        field("total_squares", e.total_squares, d[157:112]);
        field("mean", e.mean, d[173:158]);
        field("variance", e.variance, d[204:174]);
        field("std_dev", e.std_dev, d[220:205]);
        field("fill", 0, d[223:221]);
    endfunction
endclass

module testbench;

    localparam int IDLE_LIMIT = 300000;

    logic         aclk = 0;
    logic         aresetn = 0;
    logic         s_tvalid = 0;
    logic         s_tready;
    logic [31:0]  s_tdata = '0;
    logic [2:0]   s_tuser = '0;
    logic         m_tvalid;
    logic         m_tready = 0;
    logic [223:0] m_tdata;
    logic         m_tuser;

    cell_stats_scoreboard sb = new();
    bit quiet = 0;
    bit hold_long = 0;
    int idle_cycles = 0;

    per_cell_running_statistics u_top (.*);

    always begin
        #5 aclk = 1;
        #5 aclk = 0;
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) sb.check_result(m_tdata, m_tuser);
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("per_cell_running_statistics: mismatch");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin : result_sink
        int n;
        @(posedge aresetn);
        forever begin
            if (hold_long) begin
                n = 400;
                hold_long = 0;
            end else begin
                n = quiet ? 0 : $urandom_range(0, 11);
            end
            if (n != 0) begin
                m_tready <= 0;
                repeat (n) @(posedge aclk);
            end
            m_tready <= 1;
            do @(posedge aclk); while (!(m_tvalid && m_tready));
        end
    end

    task automatic send(pcrs_pkg::kind_t kind, logic [15:0] cell_idx,
                        logic [15:0] x, logic present);
        int gap;
        gap = quiet ? 0 : $urandom_range(0, 11);
        if (gap != 0) begin
            s_tvalid <= 0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1;
        s_tdata <= {x, cell_idx};
        s_tuser <= {present, kind};
        do @(posedge aclk); while (!s_tready);
        sb.note_input(kind, cell_idx, x, present);
    endtask

    task automatic drain();
        s_tvalid <= 0;
        while (sb.pending_readouts.size() != 0) @(posedge aclk);
    endtask

    function automatic logic [15:0] pick_value();
        case ($urandom_range(0, 9))
            0: return 16'h7FFF;
            1: return 16'h8000;
            2: return 16'($urandom_range(0, 3)) - 16'd2;
            3, 4: return 16'($urandom_range(0, 2047)) - 16'd1024;
            default: return 16'($urandom);
        endcase
    endfunction

    initial begin
        int k;
        logic [15:0] cell_idx;
        repeat (5) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);

        send(pcrs_pkg::KIND_READ, 16'd0, 16'h0000, 1'b0);
        send(pcrs_pkg::KIND_ACCUM, 16'd0, 16'h7FFF, 1'b1);
        send(pcrs_pkg::KIND_ACCUM, 16'd0, 16'h8000, 1'b1);
        send(pcrs_pkg::KIND_ACCUM, 16'd0, 16'h0000, 1'b1);
        send(pcrs_pkg::KIND_ACCUM, 16'd0, 16'h1234, 1'b0);
        send(pcrs_pkg::KIND_READ, 16'd0, 16'hFFFF, 1'b1);
        send(pcrs_pkg::KIND_ACCUM, 16'd65535, 16'hFFFF, 1'b1);
        send(pcrs_pkg::KIND_ACCUM, 16'd65535, 16'h0100, 1'b1);
        send(pcrs_pkg::KIND_READ, 16'd65535, 16'h0000, 1'b0);
        send(pcrs_pkg::KIND_READ, 16'd1, 16'h0000, 1'b0);
        send(pcrs_pkg::KIND_CLEAR, 16'd0, 16'h0000, 1'b0);
        send(pcrs_pkg::KIND_READ, 16'd0, 16'h0000, 1'b0);
        send(pcrs_pkg::KIND_NONE, 16'd2, 16'h0100, 1'b1);
        send(pcrs_pkg::KIND_READ, 16'd2, 16'h0000, 1'b0);
        send(pcrs_pkg::KIND_ACCUM, 16'd2, 16'h8000, 1'b1);
        send(pcrs_pkg::KIND_READ, 16'd2, 16'h0000, 1'b0);
        send(pcrs_pkg::KIND_CLEAR, 16'd65535, 16'h0000, 1'b0);
        send(pcrs_pkg::KIND_READ, 16'd65535, 16'h0000, 1'b0);
        drain();

        for (k = 0; k < 2000; k++) begin
            if (k % 150 == 0) quiet = ($urandom_range(0, 3) == 0);
            if (k == 600) hold_long = 1;
            if (k == 1200) drain();
            cell_idx = ($urandom_range(0, 9) == 0) ? 16'($urandom)
                                                   : 16'($urandom_range(0, 15));
            case ($urandom_range(0, 19))
                0, 1, 2, 3, 4: send(pcrs_pkg::KIND_READ, cell_idx, 16'($urandom),
                                    1'($urandom_range(0, 1)));
                5: send(pcrs_pkg::KIND_CLEAR, cell_idx, 16'($urandom),
                        1'($urandom_range(0, 1)));
                6: send(pcrs_pkg::KIND_NONE, cell_idx, 16'($urandom),
                        1'($urandom_range(0, 1)));
                7: send(pcrs_pkg::KIND_ACCUM, cell_idx, 16'($urandom), 1'b0);
                default: send(pcrs_pkg::KIND_ACCUM, cell_idx, pick_value(), 1'b1);
            endcase
        end
        drain();
        repeat (200) @(posedge aclk);

        if (sb.failures == 0 && sb.pending_readouts.size() == 0) begin
            $display("per_cell_running_statistics: match");
        end else begin
            $display("per_cell_running_statistics: mismatch");
        end
        $finish;
    end
endmodule
